>>> rtl/assert_macros.svh
// Assertion macros used by the top RTL module; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTARP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntarp: same-cycle check failed");
`define NTARP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntarp: next-cycle check failed");
`else
`define NTARP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NTARP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ntarp_pkg.sv
// Shared types, codes and sizes of the neighbor table with aging.
package ntarp_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 16;
    localparam int TIMER_W     = 16;
    localparam int RND_W       = 16;
    localparam int BIT_W       = $clog2(RND_W);
    localparam int EC_W        = 5;

    // Request opcodes.
    localparam logic [1:0] OP_ANNOUNCE = 2'd0;
    localparam logic [1:0] OP_FORWARD  = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // Response status codes.
    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FORWARDED = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;
    localparam logic [2:0] ST_TICK      = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] neighbor_addr;
        logic [RND_W-1:0]  random_value;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] next_hop;
        logic [EC_W-1:0]   entry_count;
        logic [EC_W-1:0]   expired_count;
    } rsp_t;

    // Table write port.
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [ADDR_W-1:0]  addr;
        logic [TIMER_W-1:0] timer;
    } tbl_wr_t;

    // Table read data.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TIMER_W-1:0] timer;
    } tbl_rd_t;

    // Modulo unit command and status.
    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

>>> rtl/neighbor_table_aging_random_pick.sv
// Announce walks the table one entry per cycle until it hits the address or the end.
// Tick walks every entry. Forward runs the bit-serial modulo, table read, pick and
// response, or goes straight to its response on an empty table, as unused opcodes do.
// One request at a time: the next request is taken the cycle after the response is loaded,
// and a response that is not taken holds the block in its final state.
// Reset (rst_n, asynchronous, active low) empties the table and sets timeout to 7680.
module neighbor_table_aging_random_pick (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ntarp_pkg::TIMER_W-1:0]   cfg_wr_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  ntarp_pkg::req_t                 req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output ntarp_pkg::rsp_t                 rsp
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DIV,
        S_PICK,
        S_AGE,
        S_DONE
    } state_t;

    state_t                          state_reg;
    ntarp_pkg::req_t                 item_reg;
    logic [ntarp_pkg::TIMER_W-1:0]   timeout_reg;
    logic [ntarp_pkg::CNT_W-1:0]     count_reg;
    logic [ntarp_pkg::CNT_W-1:0]     scan_reg;
    logic [ntarp_pkg::CNT_W-1:0]     keep_reg;
    logic [ntarp_pkg::CNT_W-1:0]     exp_reg;
    logic [2:0]                      res_status_reg;
    logic [ntarp_pkg::ADDR_W-1:0]    res_hop_reg;
    logic [ntarp_pkg::CNT_W-1:0]     res_exp_reg;
    logic                            rsp_valid_reg;
    ntarp_pkg::rsp_t                 rsp_reg;

    ntarp_pkg::tbl_wr_t              tbl_wr;
    ntarp_pkg::tbl_rd_t              tbl_rd;
    logic [ntarp_pkg::IDX_W-1:0]     rd_idx;
    ntarp_pkg::mod_req_t             mod_req;
    ntarp_pkg::mod_rsp_t             mod_rsp;
    logic                            accept;
    logic [ntarp_pkg::CNT_W-1:0]     scan_inc;
    logic                            scan_end;
    logic                            hit;
    logic                            has_room;
    logic                            expiring;
    logic                            count_over;
    logic                            fwd_rsp;
    logic                            exp_rsp;
    logic                            walk_start;

    ntarp_table u_table (
        .clk    (clk),
        .wr     (tbl_wr),
        .rd_idx (rd_idx),
        .rd     (tbl_rd)
    );

    ntarp_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Scan status shared by lookup and aging; read data belongs to scan_reg.
    assign scan_inc = scan_reg + 1'b1;
    assign scan_end = (scan_reg == count_reg);
    assign hit      = !scan_end && (tbl_rd.addr == item_reg.neighbor_addr);
    assign has_room = (count_reg < ntarp_pkg::CNT_W'(ntarp_pkg::TABLE_DEPTH));
    assign expiring = (tbl_rd.timer <= ntarp_pkg::TIMER_W'(1));

    // The modulo unit starts on a forward request to a non-empty table.
    always_comb
    begin
        mod_req.start    = accept && (req.op == ntarp_pkg::OP_FORWARD) && (count_reg != '0);
        mod_req.dividend = req.random_value;
        mod_req.divisor  = count_reg;
    end

    // Read index: the picked position while forwarding, the next scan position while
    // walking, and the first entry otherwise so that a new walk finds it ready.
    always_comb
    begin
        unique case (state_reg)
            S_DIV:
            begin
                rd_idx = mod_rsp.remainder[ntarp_pkg::IDX_W-1:0];
            end
            S_FIND, S_AGE:
            begin
                rd_idx = scan_inc[ntarp_pkg::IDX_W-1:0];
            end
            default:
            begin
                rd_idx = '0;
            end
        endcase
    end

    // Table writes: refresh, append, and compaction of surviving entries.
    always_comb
    begin
        tbl_wr.en    = 1'b0;
        tbl_wr.idx   = scan_reg[ntarp_pkg::IDX_W-1:0];
        tbl_wr.addr  = item_reg.neighbor_addr;
        tbl_wr.timer = timeout_reg;
        unique case (state_reg)
            S_FIND:
            begin
                if (hit)
                begin
                    tbl_wr.en = 1'b1;
                end
                else if (scan_end && has_room)
                begin
                    tbl_wr.en  = 1'b1;
                    tbl_wr.idx = count_reg[ntarp_pkg::IDX_W-1:0];
                end
            end
            S_AGE:
            begin
                if (!scan_end && !expiring)
                begin
                    tbl_wr.en    = 1'b1;
                    tbl_wr.idx   = keep_reg[ntarp_pkg::IDX_W-1:0];
                    tbl_wr.addr  = tbl_rd.addr;
                    tbl_wr.timer = tbl_rd.timer - ntarp_pkg::TIMER_W'(1);
                end
            end
            default:
            begin
                tbl_wr.en = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ntarp_pkg::TIMER_W'(7680);
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Sequencer with its counters and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            keep_reg       <= '0;
            exp_reg        <= '0;
            res_status_reg <= ntarp_pkg::ST_TICK;
            res_hop_reg    <= '0;
            res_exp_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            item_reg       <= '0;
        end
        else
        begin
            // A taken response clears the valid flag unless a new one is loaded.
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg    <= req;
                        scan_reg    <= '0;
                        keep_reg    <= '0;
                        exp_reg     <= '0;
                        res_hop_reg <= '0;
                        res_exp_reg <= '0;
                        unique case (req.op)
                            ntarp_pkg::OP_ANNOUNCE:
                            begin
                                state_reg <= S_FIND;
                            end
                            ntarp_pkg::OP_FORWARD:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_reg <= ntarp_pkg::ST_NONE;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            ntarp_pkg::OP_TICK:
                            begin
                                state_reg <= S_AGE;
                            end
                            default:
                            begin
                                res_status_reg <= ntarp_pkg::ST_TICK;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (hit)
                    begin
                        res_status_reg <= ntarp_pkg::ST_REFRESHED;
                        state_reg      <= S_DONE;
                    end
                    else if (scan_end)
                    begin
                        if (has_room)
                        begin
                            count_reg      <= count_reg + 1'b1;
                            res_status_reg <= ntarp_pkg::ST_ADDED;
                        end
                        else
                        begin
                            res_status_reg <= ntarp_pkg::ST_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                    end
                end
                S_DIV:
                begin
                    if (mod_rsp.done)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    res_hop_reg    <= tbl_rd.addr;
                    res_status_reg <= ntarp_pkg::ST_FORWARDED;
                    state_reg      <= S_DONE;
                end
                S_AGE:
                begin
                    if (scan_end)
                    begin
                        count_reg      <= keep_reg;
                        res_exp_reg    <= exp_reg;
                        res_status_reg <= ntarp_pkg::ST_TICK;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                        if (expiring)
                        begin
                            exp_reg <= exp_reg + 1'b1;
                        end
                        else
                        begin
                            keep_reg <= keep_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.status        <= res_status_reg;
                        rsp_reg.next_hop      <= res_hop_reg;
                        rsp_reg.entry_count   <= ntarp_pkg::EC_W'(count_reg);
                        rsp_reg.expired_count <= ntarp_pkg::EC_W'(res_exp_reg);
                        rsp_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Conditions watched by the checks below.
    assign count_over = (count_reg > ntarp_pkg::CNT_W'(ntarp_pkg::TABLE_DEPTH));
    assign fwd_rsp    = rsp_valid && (rsp.status == ntarp_pkg::ST_FORWARDED);
    assign exp_rsp    = rsp_valid && (rsp.expired_count != '0);
    assign walk_start = accept
                        && ((req.op == ntarp_pkg::OP_FORWARD && count_reg != '0)
                            || req.op == ntarp_pkg::OP_ANNOUNCE
                            || req.op == ntarp_pkg::OP_TICK);

    // The table never holds more entries than its depth.
    `NTARP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, !count_over)
    // A forward response always reports a non-empty table.
    `NTARP_ASSERT_IMP(a_fwd_nonempty, clk, rst_n, fwd_rsp, rsp.entry_count != '0)
    // Only a tick reports expired entries.
    `NTARP_ASSERT_IMP(a_exp_tick_only, clk, rst_n, exp_rsp, rsp.status == ntarp_pkg::ST_TICK)
    // A request that starts a table walk or a modulo keeps the block busy next cycle.
    `NTARP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, walk_start, !req_ready)

endmodule

>>> rtl/ntarp_table.sv
// Entry storage: neighbor addresses and age timers, one write and one registered read port.
module ntarp_table (
    input  logic                         clk,
    input  ntarp_pkg::tbl_wr_t           wr,
    input  logic [ntarp_pkg::IDX_W-1:0]  rd_idx,
    output ntarp_pkg::tbl_rd_t           rd
);

    logic [ntarp_pkg::ADDR_W-1:0]  addr_mem  [ntarp_pkg::TABLE_DEPTH];
    logic [ntarp_pkg::TIMER_W-1:0] timer_mem [ntarp_pkg::TABLE_DEPTH];

    // Single write port; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            addr_mem[wr.idx]  <= wr.addr;
            timer_mem[wr.idx] <= wr.timer;
        end
    end

    // Registered read port: data for an index appears the cycle after it is presented.
    always_ff @(posedge clk)
    begin
        rd.addr  <= addr_mem[rd_idx];
        rd.timer <= timer_mem[rd_idx];
    end

endmodule

>>> rtl/ntarp_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
module ntarp_mod (
    input  logic                clk,
    input  logic                rst_n,
    input  ntarp_pkg::mod_req_t req,
    output ntarp_pkg::mod_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ntarp_pkg::BIT_W-1:0]   bit_reg;
    logic [ntarp_pkg::RND_W-1:0]   dvd_reg;
    logic [ntarp_pkg::CNT_W-1:0]   dvs_reg;
    logic [ntarp_pkg::CNT_W-1:0]   rem_reg;
    logic [ntarp_pkg::CNT_W:0]     part;
    logic [ntarp_pkg::CNT_W-1:0]   rem_next;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        part = {rem_reg, dvd_reg[ntarp_pkg::RND_W-1]};
        if (part >= {1'b0, dvs_reg})
        begin
            rem_next = ntarp_pkg::CNT_W'(part - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = part[ntarp_pkg::CNT_W-1:0];
        end
    end

    // Control: start loads the operands, the last bit raises done for a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= ntarp_pkg::BIT_W'(ntarp_pkg::RND_W - 1);
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ntarp_pkg::RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> tb/sv/neighbor_table_checker.sv
// Checker for the neighbor table: predicts each response and compares it with the block.
`timescale 1ns / 100ps

module neighbor_table_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ntarp_pkg::TIMER_W-1:0] cfg_wr_data,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  ntarp_pkg::req_t               req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  ntarp_pkg::rsp_t               rsp,
    output int unsigned                   mismatches,
    output int unsigned                   awaiting
);

    localparam logic [ntarp_pkg::TIMER_W-1:0] LIFETIME_AT_RESET = 16'd7680;
    localparam int unsigned                   REPORT_LIMIT      = 10;

    // Shadow copy of the table, kept in insertion order.
    logic [ntarp_pkg::ADDR_W-1:0]  nbr_addr  [ntarp_pkg::TABLE_DEPTH];
    logic [ntarp_pkg::TIMER_W-1:0] nbr_timer [ntarp_pkg::TABLE_DEPTH];
    int unsigned                   nbr_count;
    logic [ntarp_pkg::TIMER_W-1:0] lifetime;

    // Responses predicted for accepted requests, oldest first.
    ntarp_pkg::rsp_t               due_rsp [$];
    ntarp_pkg::rsp_t               want;

    // Applies one request to the shadow table and returns the response it causes.
    function automatic ntarp_pkg::rsp_t age_table_step(input ntarp_pkg::req_t item);
        ntarp_pkg::rsp_t o;
        int unsigned     i;
        int unsigned     keep;
        int unsigned     dropped;
        bit              hit;
        o       = '0;
        hit     = 1'b0;
        keep    = 0;
        dropped = 0;
        unique case (item.op)
            ntarp_pkg::OP_ANNOUNCE:
            begin
                for (i = 0; i < nbr_count; i++)
                begin
                    if (!hit && nbr_addr[i] == item.neighbor_addr)
                    begin
                        nbr_timer[i] = lifetime;
                        hit          = 1'b1;
                    end
                end
                if (hit)
                begin
                    o.status = ntarp_pkg::ST_REFRESHED;
                end
                else if (nbr_count < ntarp_pkg::TABLE_DEPTH)
                begin
                    nbr_addr[nbr_count]  = item.neighbor_addr;
                    nbr_timer[nbr_count] = lifetime;
                    nbr_count++;
                    o.status = ntarp_pkg::ST_ADDED;
                end
                else
                begin
                    o.status = ntarp_pkg::ST_FULL;
                end
            end
            ntarp_pkg::OP_FORWARD:
            begin
                if (nbr_count == 0)
                begin
                    o.status = ntarp_pkg::ST_NONE;
                end
                else
                begin
                    o.status   = ntarp_pkg::ST_FORWARDED;
                    o.next_hop = nbr_addr[item.random_value % nbr_count];
                end
            end
            ntarp_pkg::OP_TICK:
            begin
                // A timer at zero or one runs out; survivors slide down in order.
                for (i = 0; i < nbr_count; i++)
                begin
                    if (nbr_timer[i] <= 1)
                    begin
                        dropped++;
                    end
                    else
                    begin
                        nbr_addr[keep]  = nbr_addr[i];
                        nbr_timer[keep] = nbr_timer[i] - 1'b1;
                        keep++;
                    end
                end
                nbr_count       = keep;
                o.status        = ntarp_pkg::ST_TICK;
                o.expired_count = dropped[ntarp_pkg::EC_W-1:0];
            end
            default:
            begin
                o.status = ntarp_pkg::ST_TICK;
            end
        endcase
        o.entry_count = nbr_count[ntarp_pkg::EC_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbr_count  = 0;
            lifetime   = LIFETIME_AT_RESET;
            due_rsp.delete();
            mismatches = 0;
            awaiting   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lifetime = cfg_wr_data;
            end

            // Responses are checked before this edge's request is predicted.
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: response with no request pending: status %0d hop %h",
                                 $realtime, rsp.status, rsp.next_hop);
                    end
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.next_hop !== want.next_hop ||
                        rsp.entry_count !== want.entry_count ||
                        rsp.expired_count !== want.expired_count)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected status %0d hop %h count %0d expired %0d",
                                     $realtime, want.status, want.next_hop,
                                     want.entry_count, want.expired_count);
                            $display("%0t: actual   status %0d hop %h count %0d expired %0d",
                                     $realtime, rsp.status, rsp.next_hop,
                                     rsp.entry_count, rsp.expired_count);
                        end
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                due_rsp.push_back(age_table_step(req));
            end

            awaiting = due_rsp.size();
        end
    end

endmodule

>>> tb/sv/neighbor_table_aging_random_pick_test.sv
// Top of the neighbor table testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module neighbor_table_aging_random_pick_test;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_COUNT = 8;
    localparam int         PHASE_ITEMS = 100;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [ntarp_pkg::TIMER_W-1:0] cfg_wr_data;
    logic                          req_valid;
    logic                          req_ready;
    ntarp_pkg::req_t               req;
    logic                          rsp_valid;
    logic                          rsp_ready;
    ntarp_pkg::rsp_t               rsp;

    int unsigned                   mismatches;
    int unsigned                   awaiting;

    // Idle control shared by the request and response sides.
    bit                            calm     = 1'b1;
    int                            idle_pct = 0;
    int                            stall_left;

    logic [ntarp_pkg::TIMER_W-1:0] lifetimes [PHASE_COUNT] =
        '{16'd3, 16'd1, 16'd5, 16'd2, 16'd12, 16'd0, 16'd7680, 16'd65535};
    logic [ntarp_pkg::ADDR_W-1:0]  pool_base;
    int                            k;
    int                            ph;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    neighbor_table_aging_random_pick u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    neighbor_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .awaiting    (awaiting)
    );

    // Response side backpressure in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            stall_left <= 0;
            rsp_ready  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(0, 7);
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic ntarp_pkg::req_t pack_req(input logic [1:0] op,
                                                 input logic [ntarp_pkg::ADDR_W-1:0] addr,
                                                 input logic [ntarp_pkg::RND_W-1:0] rnd);
        ntarp_pkg::req_t item;
        item.op            = op;
        item.neighbor_addr = addr;
        item.random_value  = rnd;
        return item;
    endfunction

    // Mostly addresses from a small pool so that refresh, fill and drop all occur.
    function automatic ntarp_pkg::req_t random_request(
        input logic [ntarp_pkg::ADDR_W-1:0] base);
        int                           pick;
        logic [1:0]                   op;
        logic [ntarp_pkg::ADDR_W-1:0] addr;
        logic [ntarp_pkg::RND_W-1:0]  rnd;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = ntarp_pkg::OP_ANNOUNCE;
        else if (pick < 70)
            op = ntarp_pkg::OP_FORWARD;
        else if (pick < 96)
            op = ntarp_pkg::OP_TICK;
        else
            op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            addr = base + ntarp_pkg::ADDR_W'($urandom_range(0, 23));
        else if (pick < 95)
            addr = ntarp_pkg::ADDR_W'($urandom);
        else
            addr = pick[0] ? 16'hFFFF : 16'h0000;
        rnd = ntarp_pkg::RND_W'($urandom);
        return pack_req(op, addr, rnd);
    endfunction

    // Presents one request, with an optional idle burst first, and waits for acceptance.
    task automatic send(input ntarp_pkg::req_t item);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 8);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Waits until every response has come back, then writes the timeout register.
    task automatic set_lifetime(input logic [ntarp_pkg::TIMER_W-1:0] ticks);
        req_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        req_valid   = 1'b0;
        req         = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, unused opcode and refresh at the reset timeout.
        send(pack_req(ntarp_pkg::OP_FORWARD, 16'h0000, 16'h0000));
        send(pack_req(ntarp_pkg::OP_TICK, 16'hFFFF, 16'hFFFF));
        send(pack_req(OP_UNUSED, 16'hFFFF, 16'hFFFF));
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'h0000, 16'hFFFF));
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'hFFFF, 16'h0000));
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'h0000, 16'h0000));
        send(pack_req(ntarp_pkg::OP_FORWARD, 16'h0000, 16'hFFFF));
        send(pack_req(ntarp_pkg::OP_FORWARD, 16'hFFFF, 16'h0000));

        // Fill the table with one-tick timers, overflow it, then expire every entry at once.
        set_lifetime(16'd1);
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'h0000, 16'h0000));
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'hFFFF, 16'h0000));
        for (k = 0; k < ntarp_pkg::TABLE_DEPTH - 2; k++)
            send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'h0001 << k, 16'h0000));
        send(pack_req(ntarp_pkg::OP_ANNOUNCE, 16'h5A5A, 16'h0000));
        send(pack_req(ntarp_pkg::OP_FORWARD, 16'h0000, 16'hFFFF));
        send(pack_req(ntarp_pkg::OP_TICK, 16'h0000, 16'h0000));

        // Random phases, one timeout each; the first and last run without idling.
        pool_base = ntarp_pkg::ADDR_W'($urandom);
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_lifetime(lifetimes[ph]);
            calm     = (ph == PHASE_COUNT - 1) || (ph == 0);
            idle_pct = 20 + (ph % 3) * 15;
            repeat (PHASE_ITEMS) send(random_request(pool_base));
        end

        // Drain the last responses and give the verdict.
        req_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ntarp_pkg.sv
rtl/ntarp_table.sv
rtl/ntarp_mod.sv
rtl/neighbor_table_aging_random_pick.sv
tb/sv/neighbor_table_checker.sv
tb/sv/neighbor_table_aging_random_pick_test.sv
